// ===== design/nzmie_pkg.sv =====
package nzmie_pkg;

    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_INDEX_BITS = 16;

    localparam int COORD_W   = 16;
    localparam int AXIS_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int DIMS_W    = 3;
    localparam int SIZE_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int Q_DEPTH   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMS_IN_USE     = 8'd0,
        REG_SIZE_AXIS_ONE   = 8'd1,
        REG_SIZE_AXIS_TWO   = 8'd2,
        REG_SIZE_AXIS_THREE = 8'd3
    } nzmie_reg_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } nzmie_q_status_t;

    // extent of one axis; axes past three have extent one, zero reads as one
    function automatic logic [SIZE_W-1:0] axis_extent(input int axis,
                                                      input logic [SIZE_W-1:0] s1,
                                                      input logic [SIZE_W-1:0] s2,
                                                      input logic [SIZE_W-1:0] s3);
        logic [SIZE_W-1:0] s;
        s = SIZE_W'(1);
        if (axis == 1) s = s1;
        else if (axis == 2) s = s2;
        else if (axis == 3) s = s3;
        if (s == '0) s = SIZE_W'(1);
        return s;
    endfunction

endpackage

// ===== design/nonzero_multi_index_emitter_unit.sv =====
// nonzero coordinate emitter
// s_ channel takes array elements in row-major order, one request per element;
// s_tlast marks the final element and restarts the index counter after it.
// m_ channel gives, for each nonzero element, one request per axis from axis 0
// upward: the coordinate in m_tdata, the axis in m_tuser, m_tlast on the last
// coordinate of the row. zero elements give nothing.
// cfg_ channel writes dims_in_use and the extents of axes 1 to 3; the user must
// write them only while idle; the block itself does not enforce it.
// an element is accepted every cycle while the four-entry queue has room; a
// nonzero element occupies the output for one coordinate per axis in use, so
// with steady nonzero input the single output register sets the rate, emitting
// one coordinate per cycle while m_tready is high, each loaded from the queue.
// when m_tready is low the output holds and the queue fills; once full, s_tready
// falls until the back end drains an entry.
// reset (aresetn low, synchronous) clears the counter, queue and output valid and
// returns every register to 1.
module nonzero_multi_index_emitter_unit import nzmie_pkg::*; #(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,   // [31:0] element_value
    input  logic                 s_tlast,   // final_element
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COORD_W-1:0]   m_tdata,   // [15:0] coordinate
    output logic [AXIS_W-1:0]    m_tuser,   // [1:0] axis_number
    output logic                 m_tlast    // row_end
);

    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int EW = MAX_DIMS * COORD_W + DW;

    nzmie_q_status_t q_status;
    logic            push, pop;
    logic [EW-1:0]   push_data, head_data;

    nzmie_front #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    nzmie_queue #(
        .EW (EW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    nzmie_back #(
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_data (head_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/nzmie_front.sv =====
module nzmie_front import nzmie_pkg::*; #(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    localparam int DW        = $clog2(MAX_DIMS + 1),
    localparam int EW        = MAX_DIMS * COORD_W + DW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,
    input  logic                 s_tlast,
    input  nzmie_q_status_t      q_status,
    output logic                 push,
    output logic [EW-1:0]        push_data
);

    localparam int CW = (INDEX_BITS + 1 > SIZE_W + 1) ? INDEX_BITS + 1 : SIZE_W + 1;

    logic [DIMS_W-1:0]     dims_reg;
    logic [SIZE_W-1:0]     size1_reg, size2_reg, size3_reg;
    logic [INDEX_BITS-1:0] cnt_reg  [MAX_DIMS];
    logic [INDEX_BITS-1:0] cnt_next [MAX_DIMS];
    logic [DW-1:0]         d_act;
    logic                  accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg  <= DIMS_W'(1);
            size1_reg <= SIZE_W'(1);
            size2_reg <= SIZE_W'(1);
            size3_reg <= SIZE_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DIMS_IN_USE:     dims_reg  <= cfg_data[DIMS_W-1:0];
                REG_SIZE_AXIS_ONE:   size1_reg <= cfg_data[SIZE_W-1:0];
                REG_SIZE_AXIS_TWO:   size2_reg <= cfg_data[SIZE_W-1:0];
                REG_SIZE_AXIS_THREE: size3_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        int dv;
        dv = int'(dims_reg);
        if (dv == 0) dv = 1;
        if (dv > MAX_DIMS) dv = MAX_DIMS;
        d_act = DW'(dv);
    end

    assign s_tready = q_status.not_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (s_tdata != '0);

    always_comb begin
        push_data = '0;
        for (int a = 0; a < MAX_DIMS; a++) begin
            if (a < int'(d_act)) push_data[a*COORD_W +: COORD_W] = COORD_W'(cnt_reg[a]);
        end
        push_data[EW-1 -: DW] = d_act;
    end

    // mixed-radix advance; wrap tests are independent, only the carry ripples
    always_comb begin
        logic          c;
        logic [CW-1:0] inc;
        c = 1'b1;
        for (int a = 0; a < MAX_DIMS; a++) cnt_next[a] = '0;
        for (int a = MAX_DIMS - 1; a >= 1; a--) begin
            inc = CW'(cnt_reg[a]) + CW'(1);
            if (a < int'(d_act)) begin
                if (inc >= CW'(axis_extent(a, size1_reg, size2_reg, size3_reg))) begin
                    cnt_next[a] = c ? '0 : cnt_reg[a];
                end else begin
                    cnt_next[a] = c ? INDEX_BITS'(inc) : cnt_reg[a];
                    c = 1'b0;
                end
            end
        end
        cnt_next[0] = cnt_reg[0];
        if (c && (cnt_reg[0] != '1)) cnt_next[0] = cnt_reg[0] + INDEX_BITS'(1);
        if (s_tlast) begin
            for (int a = 0; a < MAX_DIMS; a++) cnt_next[a] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < MAX_DIMS; a++) cnt_reg[a] <= '0;
        end else if (accept) begin
            for (int a = 0; a < MAX_DIMS; a++) cnt_reg[a] <= cnt_next[a];
        end
    end

endmodule

// ===== design/nzmie_queue.sv =====
module nzmie_queue import nzmie_pkg::*; #(
    parameter int EW = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  logic [EW-1:0]   push_data,
    input  logic            pop,
    output logic [EW-1:0]   head_data,
    output nzmie_q_status_t status
);

    localparam int PW = $clog2(Q_DEPTH);

    logic [EW-1:0] mem_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign status.not_full  = (count_reg != (PW+1)'(Q_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head_data        = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PW'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/nzmie_back.sv =====
module nzmie_back import nzmie_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    localparam int DW      = $clog2(MAX_DIMS + 1),
    localparam int EW      = MAX_DIMS * COORD_W + DW,
    localparam int AXW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  nzmie_q_status_t    q_status,
    input  logic [EW-1:0]      head_data,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COORD_W-1:0] m_tdata,
    output logic [AXIS_W-1:0]  m_tuser,
    output logic               m_tlast
);

    logic [AXW-1:0]     axis_reg;
    logic               valid_reg;
    logic [COORD_W-1:0] coord_reg;
    logic [AXIS_W-1:0]  axis_out_reg;
    logic               last_reg;
    logic               load, last_axis;
    logic [DW-1:0]      head_dims;

    assign head_dims = head_data[EW-1 -: DW];
    assign load      = q_status.not_empty && (!valid_reg || m_tready);
    assign last_axis = (int'(axis_reg) == int'(head_dims) - 1);
    assign pop       = load && last_axis;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            axis_reg  <= '0;
        end else begin
            if (load) valid_reg <= 1'b1;
            else if (m_tready) valid_reg <= 1'b0;
            if (load) axis_reg <= last_axis ? '0 : axis_reg + AXW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            coord_reg    <= head_data[int'(axis_reg)*COORD_W +: COORD_W];
            axis_out_reg <= AXIS_W'(axis_reg);
            last_reg     <= last_axis;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = coord_reg;
    assign m_tuser  = axis_out_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== sim/tb_nonzero_multi_index_emitter_unit.sv =====
`timescale 1ns / 1ps

module tb_nonzero_multi_index_emitter_unit import nzmie_pkg::*;;

    localparam int MAX_AXES      = DEF_MAX_DIMS;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 25;
    localparam int PRESSURE_PHASE = 3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

    typedef enum logic {ROW_ELEM, ROW_CFG} row_kind_t;

    typedef struct {
        logic [COORD_W-1:0] coord;
        logic [AXIS_W-1:0]  axis;
        logic               row_end;
    } coord_rec_t;

    typedef struct {
        row_kind_t                   kind;
        logic [CFG_IDX_W-1:0]        reg_idx;
        logic [VALUE_W-1:0]          value;
        logic                        last;
        logic                        known;
        int                          n;
        logic [0:3][COORD_W-1:0]     c;
    } elem_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata   = '0;   // [31:0] element_value
    logic                 s_tlast   = 1'b0; // final_element
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [COORD_W-1:0]   m_tdata;          // [15:0] coordinate
    logic [AXIS_W-1:0]    m_tuser;          // [1:0] axis_number
    logic                 m_tlast;          // row_end

    nonzero_multi_index_emitter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [COORD_W-1:0] coord_cnt [MAX_AXES];
    logic [DIMS_W-1:0]  reg_dims;
    logic [SIZE_W-1:0]  reg_size [MAX_AXES];

    coord_rec_t pending_coords [$];
    elem_row_t  directed_rows  [$];

    int  error_count    = 0;
    int  coords_checked = 0;
    int  items_sent     = 0;
    int  reg_writes     = 0;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;
    bit  quiet          = 1'b0;
    bit  burst          = 1'b0;
    bit  pressure_armed = 1'b0;
    bit  pressure_done  = 1'b0;

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SIZE_W:0] extent_of(input int a);
        logic [SIZE_W-1:0] s;
        s = (a >= 1 && a <= 3) ? reg_size[a] : SIZE_W'(1);
        if (s == '0) s = SIZE_W'(1);
        return {1'b0, s};
    endfunction

    // coordinates of one element, then step the mixed-radix counter
    function automatic int predict_coords(input logic [VALUE_W-1:0] v, input logic l,
                                          output coord_rec_t row [MAX_AXES]);
        int   d;
        logic carry;
        d = (reg_dims == '0) ? 1 : ((int'(reg_dims) > MAX_AXES) ? MAX_AXES : int'(reg_dims));
        for (int a = d; a < MAX_AXES; a++) coord_cnt[a] = '0;
        if (v != '0) begin
            for (int a = 0; a < d; a++)
                row[a] = '{coord: coord_cnt[a], axis: AXIS_W'(a), row_end: (a == d - 1)};
        end
        if (l) begin
            for (int a = 0; a < MAX_AXES; a++) coord_cnt[a] = '0;
        end else begin
            carry = 1'b1;
            for (int a = d - 1; a >= 1 && carry; a--) begin
                if ({1'b0, coord_cnt[a]} + 1 >= extent_of(a)) begin
                    coord_cnt[a] = '0;
                end else begin
                    coord_cnt[a] = coord_cnt[a] + 1'b1;
                    carry = 1'b0;
                end
            end
            // axis 0 sticks at the top of its range
            if (carry && coord_cnt[0] != '1) coord_cnt[0] = coord_cnt[0] + 1'b1;
        end
        return (v != '0) ? d : 0;
    endfunction

    function automatic void add_known(input logic [VALUE_W-1:0] v, input logic l, input int n,
                                      input int c0 = 0, input int c1 = 0,
                                      input int c2 = 0, input int c3 = 0);
        elem_row_t r;
        r.kind  = ROW_ELEM;
        r.reg_idx = '0;
        r.value = v;
        r.last  = l;
        r.known = 1'b1;
        r.n     = n;
        r.c     = {COORD_W'(c0), COORD_W'(c1), COORD_W'(c2), COORD_W'(c3)};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_elem(input logic [VALUE_W-1:0] v, input logic l);
        add_known(v, l, 0);
        directed_rows[$].known = 1'b0;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
        add_known(VALUE_W'(data), 1'b0, 0);
        directed_rows[$].kind    = ROW_CFG;
        directed_rows[$].reg_idx = idx;
        directed_rows[$].known   = 1'b0;
    endfunction

    function automatic elem_row_t random_row();
        elem_row_t r;
        int        k;
        k = $urandom_range(0, 99);
        r.kind    = ROW_ELEM;
        r.reg_idx = '0;
        r.known   = 1'b0;
        r.n       = 0;
        r.c       = '0;
        if (k < 40)      r.value = '0;
        else if (k < 55) r.value = $urandom;
        else if (k < 65) r.value = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
        else if (k < 72) r.value = $urandom_range(0, 1) ? '1 : {1'b1, {(VALUE_W-1){1'b0}}};
        else             r.value = VALUE_W'($urandom_range(1, 15));
        r.last = ($urandom_range(0, 14) == 0);
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 70) return SIZE_W'($urandom_range(1, 4));
        if (r < 90) return SIZE_W'($urandom_range(5, 40));
        return SIZE_W'($urandom_range(65533, 65535));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DIMS_IN_USE:     reg_dims    = data[DIMS_W-1:0];
            REG_SIZE_AXIS_ONE:   reg_size[1] = data;
            REG_SIZE_AXIS_TWO:   reg_size[2] = data;
            REG_SIZE_AXIS_THREE: reg_size[3] = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_row(input elem_row_t r);
        int         gap;
        int         n;
        coord_rec_t got [MAX_AXES];
        coord_rec_t rec;
        gap = (quiet || burst) ? 0 : pick_pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.value;
        s_tlast  <= r.last;
        do @(posedge aclk); while (!s_tready);
        n = predict_coords(r.value, r.last, got);
        if (r.known) begin
            for (int i = 0; i < r.n; i++) begin
                rec = '{coord: r.c[i], axis: AXIS_W'(i), row_end: (i == r.n - 1)};
                pending_coords.insert(pending_coords.size(), rec);
            end
        end else begin
            for (int i = 0; i < n; i++) pending_coords.insert(pending_coords.size(), got[i]);
        end
        items_sent++;
    endtask

    // drain the output, then keep s_tvalid low while the design settles
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_coords.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_coord();
        coord_rec_t want;
        if (pending_coords.size() == 0) begin
            $error("unexpected request: coordinate %0d axis %0d row_end %0d",
                   m_tdata, m_tuser, m_tlast);
            error_count++;
        end else begin
            want = pending_coords.pop_front();
            if (m_tdata !== want.coord) begin
                $error("coordinate: expected %0d, got %0d", want.coord, m_tdata);
                error_count++;
            end
            if (m_tuser !== want.axis) begin
                $error("axis_number: expected %0d, got %0d", want.axis, m_tuser);
                error_count++;
            end
            if (m_tlast !== want.row_end) begin
                $error("row_end: expected %0d, got %0d", want.row_end, m_tlast);
                error_count++;
            end
            coords_checked++;
        end
    endtask

    // result side: random stalls, plus one long hold while the sender keeps pushing
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_coord();
            if (pressure_armed && !pressure_done && m_tvalid) begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                stall_left = pick_pause();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_nonzero_multi_index_emitter_unit: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        bit                 in_cfg;
        logic [CFG_DAT_W-1:0] dims_data;

        in_cfg = 1'b0;
        reg_dims = DIMS_W'(1);
        for (int a = 0; a < MAX_AXES; a++) begin
            coord_cnt[a] = '0;
            reg_size[a]  = SIZE_W'(1);
        end

        // after reset: one axis, counter starts at zero
        add_known(32'h0000_0001, 1'b0, 1, 0);
        add_known(32'h0000_0000, 1'b0, 0);
        add_known(32'h8000_0000, 1'b0, 1, 2);
        add_known(32'hFFFF_FFFF, 1'b1, 1, 3);
        add_known(32'h7FFF_FFFF, 1'b0, 1, 0);
        // four axes, zero extent on axis three reads as one
        add_reg(REG_DIMS_IN_USE, 16'd4);
        add_reg(REG_SIZE_AXIS_ONE, 16'd2);
        add_reg(REG_SIZE_AXIS_TWO, 16'd3);
        add_reg(REG_SIZE_AXIS_THREE, 16'd0);
        add_known(32'h0000_0000, 1'b1, 0);
        add_known(32'hFFFF_FFFF, 1'b0, 4, 0, 0, 0, 0);
        add_known(32'h0000_0100, 1'b0, 4, 0, 0, 1, 0);
        add_known(32'h0000_0000, 1'b0, 0);
        add_known(32'h0001_0000, 1'b0, 4, 0, 1, 0, 0);
        add_elem(32'h5555_5555, 1'b0);
        add_elem(32'hAAAA_AAAA, 1'b0);
        add_elem(32'h8000_0001, 1'b1);
        // zero dimension count behaves as one
        add_reg(REG_DIMS_IN_USE, 16'd0);
        add_known(32'h1234_5678, 1'b0, 1, 0);
        // count above the maximum saturates; widest extents
        add_reg(REG_DIMS_IN_USE, 16'hFFFF);
        add_reg(REG_SIZE_AXIS_ONE, 16'hFFFF);
        add_reg(REG_SIZE_AXIS_TWO, 16'hFFFF);
        add_reg(REG_SIZE_AXIS_THREE, 16'hFFFF);
        add_known(32'hFFFF_FFFF, 1'b0, 4, 1, 0, 0, 0);
        add_known(32'h0000_0001, 1'b0, 4, 1, 0, 0, 1);
        add_elem(32'h4000_0000, 1'b1);
        add_reg(REG_UNMAPPED, 16'h1234);
        // extent lowered mid-array: counter above the new extent wraps and carries
        add_reg(REG_DIMS_IN_USE, 16'd2);
        add_reg(REG_SIZE_AXIS_ONE, 16'd4);
        add_known(32'h0000_0000, 1'b0, 0);
        add_known(32'h0000_0000, 1'b0, 0);
        add_known(32'h0000_0000, 1'b0, 0);
        add_reg(REG_SIZE_AXIS_ONE, 16'd2);
        add_known(32'h0000_0009, 1'b0, 2, 0, 3);
        add_known(32'hC000_0000, 1'b0, 2, 1, 0);
        add_known(32'h0000_0002, 1'b1, 2, 1, 1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (!in_cfg) begin
                    wait_idle();
                    in_cfg = 1'b1;
                end
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value[CFG_DAT_W-1:0]);
            end else begin
                if (in_cfg) begin
                    cfg_valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_row(directed_rows[i]);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            quiet = ($urandom_range(0, 3) == 0);
            burst = (ph == PRESSURE_PHASE);
            if (ph == PRESSURE_PHASE) begin
                quiet          = 1'b0;
                pressure_armed = 1'b1;
            end
            dims_data = CFG_DAT_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0) dims_data[CFG_DAT_W-1:DIMS_W] = '0;
            if ($urandom_range(0, 4) != 0) dims_data[DIMS_W-1:0] = DIMS_W'($urandom_range(1, 4));
            if ($urandom_range(0, 4) != 0) write_reg(REG_DIMS_IN_USE, dims_data);
            if ($urandom_range(0, 4) != 0) write_reg(REG_SIZE_AXIS_ONE, pick_size());
            if ($urandom_range(0, 4) != 0) write_reg(REG_SIZE_AXIS_TWO, pick_size());
            if ($urandom_range(0, 4) != 0) write_reg(REG_SIZE_AXIS_THREE, pick_size());
            cfg_valid <= 1'b0;
            repeat (PHASE_ITEMS) send_row(random_row());
        end

        wait_idle();
        $display("%0d elements sent, %0d coordinates checked, %0d register writes",
                 items_sent, coords_checked, reg_writes);
        $display("covered extremes, extent changes mid-array, a long output hold, %0d random phases",
                 RANDOM_PHASES);
        if (error_count == 0)
            $display("tb_nonzero_multi_index_emitter_unit: done, clean");
        else
            $display("tb_nonzero_multi_index_emitter_unit: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/nzmie_pkg.sv
design/nzmie_front.sv
design/nzmie_queue.sv
design/nzmie_back.sv
design/nonzero_multi_index_emitter_unit.sv
sim/tb_nonzero_multi_index_emitter_unit.sv
